[design/fencing_hit_detector_unit_defines.svh]
// ----------------------------------------------------------------------------
// Fencing hit detector assertion macros
// Shared property templates for the concurrent checks of the detector.
// ----------------------------------------------------------------------------
`ifndef FENCING_HIT_DETECTOR_UNIT_DEFINES_SVH
`define FENCING_HIT_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FHD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fhd_pkg.sv]
// ----------------------------------------------------------------------------
// Fencing hit detector package
// Types, register codes, voltage windows and per-weapon timing tables.
// ----------------------------------------------------------------------------
`default_nettype none

package fhd_pkg;

   typedef enum logic [1:0] {
      MODE_FOIL  = 2'd0,
      MODE_EPEE  = 2'd1,
      MODE_SABRE = 2'd2,
      MODE_NONE  = 2'd3
   } weapon_mode_type;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_LOCKOUT = 2'd1,
      PHASE_HOLD    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      HIT_NONE = 2'd0,
      HIT_ON   = 2'd1,
      HIT_OFF  = 2'd2
   } new_hit_type;

   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 32;
   localparam int HoldBits     = 32;

   localparam logic [CsrIndexBits-1:0] CSR_WEAPON_MODE = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_BUZZER_HOLD = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_LIGHT_HOLD  = 2'd2;

   localparam logic [HoldBits-1:0] BUZZER_HOLD_RESET = 32'd1500000;
   localparam logic [HoldBits-1:0] LIGHT_HOLD_RESET  = 32'd3500000;

   // voltage windows in ADC counts
   localparam int WinLo        = 400;
   localparam int WinHi        = 600;
   localparam int SabreWpnLo   = 315;
   localparam int SabreLameLo  = 300;
   localparam int FoilOffWpn   = 900;
   localparam int FoilOffLame  = 100;
   localparam int EpeeShortGap = 40;

   typedef struct packed {
      logic ground;
      logic foil_on;
      logic foil_off;
      logic foil_short;
      logic epee_contact;
      logic epee_short;
      logic sabre_on;
      logic sabre_short;
   } line_class_type;

   typedef struct packed {
      logic scoring;
      logic hold;
   } core_status_type;

   typedef struct packed {
      logic        on_target_a;
      logic        off_target_a;
      logic        on_target_b;
      logic        off_target_b;
      logic        short_fault_a;
      logic        short_fault_b;
      logic        strip_ground_a;
      logic        strip_ground_b;
      logic        buzzer_on;
      phase_type   phase;
      new_hit_type new_hit_a;
      new_hit_type new_hit_b;
   } result_type;

   function automatic logic [31:0] lock_time_us(weapon_mode_type mode);
      logic [31:0] t;
      case (mode)
         MODE_FOIL:  t = 32'd300000;
         MODE_EPEE:  t = 32'd45000;
         MODE_SABRE: t = 32'd170000;
         default:    t = 32'd0;
      endcase
      return t;
   endfunction

   function automatic logic [31:0] press_time_us(weapon_mode_type mode);
      logic [31:0] t;
      case (mode)
         MODE_FOIL:  t = 32'd14000;
         MODE_EPEE:  t = 32'd2000;
         MODE_SABRE: t = 32'd1000;
         default:    t = 32'd0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

[design/fhd_line_class.sv]
// ----------------------------------------------------------------------------
// Fencing hit detector line classifier
// Window compares on one fencer's samples and the opponent's lame for every weapon mode.
// ----------------------------------------------------------------------------
`default_nettype none

module fhd_line_class #(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic [SAMPLE_BITS-1:0] own_weapon,
   input  wire logic [SAMPLE_BITS-1:0] own_lame,
   input  wire logic [SAMPLE_BITS-1:0] opp_lame,
   input  wire logic [SAMPLE_BITS-1:0] own_ground,
   output fhd_pkg::line_class_type     line_class
);
   import fhd_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] WIN_LO   = SAMPLE_BITS'(WinLo);
   localparam logic [SAMPLE_BITS-1:0] WIN_HI   = SAMPLE_BITS'(WinHi);
   localparam logic [SAMPLE_BITS-1:0] SAB_W_LO = SAMPLE_BITS'(SabreWpnLo);
   localparam logic [SAMPLE_BITS-1:0] SAB_L_LO = SAMPLE_BITS'(SabreLameLo);
   localparam logic [SAMPLE_BITS-1:0] OFF_WPN  = SAMPLE_BITS'(FoilOffWpn);
   localparam logic [SAMPLE_BITS-1:0] OFF_LAME = SAMPLE_BITS'(FoilOffLame);
   localparam logic [SAMPLE_BITS-1:0] GAP      = SAMPLE_BITS'(EpeeShortGap);

   logic                   ground;
   logic                   wpn_mid;
   logic                   lame_mid;
   logic                   opp_mid;
   logic                   wpn_sab;
   logic                   lame_sab;
   logic                   opp_sab;
   logic [SAMPLE_BITS-1:0] gap;

   always_comb begin
      ground   = (own_ground > WIN_LO) && (own_ground < WIN_HI);
      wpn_mid  = (own_weapon > WIN_LO) && (own_weapon < WIN_HI);
      lame_mid = (own_lame > WIN_LO) && (own_lame < WIN_HI);
      opp_mid  = (opp_lame > WIN_LO) && (opp_lame < WIN_HI);
      wpn_sab  = (own_weapon > SAB_W_LO) && (own_weapon < WIN_HI);
      lame_sab = (own_lame > SAB_L_LO) && (own_lame < WIN_HI);
      opp_sab  = (opp_lame > SAB_L_LO) && (opp_lame < WIN_HI);
      gap      = (own_weapon >= own_lame) ? (own_weapon - own_lame)
                                          : (own_lame - own_weapon);

      line_class.ground       = ground;
      line_class.foil_off     = (own_weapon > OFF_WPN) && (opp_lame < OFF_LAME) && !ground;
      line_class.foil_on      = wpn_mid && opp_mid && !ground;
      line_class.foil_short   = wpn_mid && lame_mid;
      line_class.epee_contact = wpn_mid && lame_mid && !ground;
      line_class.epee_short   = (gap < GAP) && ((own_weapon < WIN_LO) || (own_weapon > WIN_HI));
      line_class.sabre_on     = wpn_sab && opp_sab && !ground;
      line_class.sabre_short  = wpn_sab && lame_sab;
   end

endmodule

`default_nettype wire

[design/fhd_score_core.sv]
// ----------------------------------------------------------------------------
// Fencing hit detector scoring core
// Bout state, depress qualification and lockout, buzzer and hold timers.
// ----------------------------------------------------------------------------
`default_nettype none

module fhd_score_core #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     clear,
   input  wire logic                     step,
   input  fhd_pkg::weapon_mode_type      mode,
   input  wire logic [31:0]              buzzer_hold,
   input  wire logic [31:0]              light_hold,
   input  wire logic [TIME_BITS-1:0]     now,
   input  fhd_pkg::line_class_type       class_a,
   input  fhd_pkg::line_class_type       class_b,
   output fhd_pkg::result_type           result,
   output fhd_pkg::core_status_type      status
);
   import fhd_pkg::*;

   logic [3:0]           hit_ff, hit_in, hit_mid;
   logic [1:0]           short_ff, short_in, short_mid;
   logic [1:0]           pressing_ff, pressing_in, pressing_mid;
   logic [TIME_BITS-1:0] press_start_ff [2];
   logic [TIME_BITS-1:0] press_start_in [2];
   logic [TIME_BITS-1:0] press_start_mid [2];
   logic                 scoring_ff, scoring_in;
   logic                 hold_ff, hold_in;
   logic                 buzz_ff, buzz_in;
   logic [TIME_BITS-1:0] lockout_start_ff, lockout_start_in;
   logic [TIME_BITS-1:0] hold_start_ff, hold_start_in;
   logic [TIME_BITS-1:0] buzz_start_ff, buzz_start_in;

   line_class_type       cls [2];
   logic [1:0]           own_hits [2];
   logic [TIME_BITS-1:0] press_el [2];
   logic [1:0]           act, cond, is_off, qual, new_on, new_off;
   logic [TIME_BITS-1:0] lock_time, press_time, lock_el, buzz_el, hold_el;
   logic                 open_old, open_after, in_window;
   logic                 start_now, scoring_mid, hold_mid, hold_mid2, buzz_mid;
   logic                 buzz_exp, enter_hold, hold_exp, clear_now;

   assign cls[0]      = class_a;
   assign cls[1]      = class_b;
   assign own_hits[0] = hit_ff[1:0];
   assign own_hits[1] = hit_ff[3:2];

   always_comb begin
      lock_time  = TIME_BITS'(lock_time_us(mode));
      press_time = TIME_BITS'(press_time_us(mode));
      lock_el    = now - lockout_start_ff;
      buzz_el    = now - buzz_start_ff;
      hold_el    = now - hold_start_ff;
      open_old   = lock_el < lock_time;
      in_window  = !scoring_ff || open_old;

      for (int f = 0; f < 2; f++) begin
         press_el[f]        = now - press_start_ff[f];
         act[f]             = 1'b0;
         cond[f]            = 1'b0;
         is_off[f]          = 1'b0;
         short_mid[f]       = short_ff[f];
         pressing_mid[f]    = pressing_ff[f];
         press_start_mid[f] = press_start_ff[f];
         qual[f]            = 1'b0;

         case (mode)
            MODE_FOIL: begin
               short_mid[f] = cls[f].foil_short;
               act[f]       = in_window && (own_hits[f] == 2'b00);
               cond[f]      = cls[f].foil_off || cls[f].foil_on;
               is_off[f]    = cls[f].foil_off;
            end
            MODE_EPEE: begin
               if (in_window && !own_hits[f][0]) begin
                  act[f]       = 1'b1;
                  cond[f]      = cls[f].epee_contact;
                  short_mid[f] = !cls[f].epee_contact && cls[f].epee_short;
               end
            end
            MODE_SABRE: begin
               short_mid[f] = cls[f].sabre_short;
               act[f]       = in_window && (own_hits[f] == 2'b00);
               cond[f]      = cls[f].sabre_on;
            end
            default: begin
            end
         endcase

         if (act[f]) begin
            if (cond[f]) begin
               if (!pressing_ff[f]) begin
                  pressing_mid[f]    = 1'b1;
                  press_start_mid[f] = now;
               end else begin
                  qual[f] = press_el[f] >= press_time;
               end
            end else begin
               pressing_mid[f]    = 1'b0;
               press_start_mid[f] = '0;
            end
         end

         new_on[f]  = qual[f] && !is_off[f];
         new_off[f] = qual[f] && is_off[f];
      end

      hit_mid     = hit_ff | {new_off[1], new_on[1], new_off[0], new_on[0]};
      start_now   = ((new_on | new_off) != 2'b00) && !scoring_ff;
      scoring_mid = scoring_ff || start_now;
      hold_mid    = start_now ? 1'b0 : hold_ff;
      buzz_mid    = start_now || buzz_ff;
      buzz_exp    = start_now ? (buzzer_hold == '0) : (32'(buzz_el) >= buzzer_hold);
      open_after  = start_now ? (lock_time != '0) : open_old;
      enter_hold  = scoring_mid && !hold_mid && !open_after;
      hold_mid2   = hold_mid || enter_hold;
      hold_exp    = enter_hold ? (light_hold == '0) : (32'(hold_el) >= light_hold);
      clear_now   = scoring_mid && hold_mid2 && hold_exp;

      // drop everything once the light hold has run out
      hit_in           = clear_now ? '0 : hit_mid;
      short_in         = clear_now ? '0 : short_mid;
      pressing_in      = clear_now ? '0 : pressing_mid;
      press_start_in[0] = clear_now ? '0 : press_start_mid[0];
      press_start_in[1] = clear_now ? '0 : press_start_mid[1];
      scoring_in       = clear_now ? 1'b0 : scoring_mid;
      hold_in          = clear_now ? 1'b0 : hold_mid2;
      buzz_in          = clear_now ? 1'b0 : (buzz_mid && !buzz_exp);
      lockout_start_in = clear_now ? '0 : (start_now ? now : lockout_start_ff);
      buzz_start_in    = clear_now ? '0 : (start_now ? now : buzz_start_ff);
      hold_start_in    = clear_now ? '0 : (enter_hold ? now : hold_start_ff);

      result.on_target_a    = hit_in[0];
      result.off_target_a   = hit_in[1];
      result.on_target_b    = hit_in[2];
      result.off_target_b   = hit_in[3];
      result.short_fault_a  = short_in[0];
      result.short_fault_b  = short_in[1];
      result.strip_ground_a = cls[0].ground;
      result.strip_ground_b = cls[1].ground;
      result.buzzer_on      = buzz_in;
      result.phase          = !scoring_in ? PHASE_IDLE : (hold_in ? PHASE_HOLD : PHASE_LOCKOUT);
      result.new_hit_a      = new_on[0] ? HIT_ON : (new_off[0] ? HIT_OFF : HIT_NONE);
      result.new_hit_b      = new_on[1] ? HIT_ON : (new_off[1] ? HIT_OFF : HIT_NONE);
   end

   assign status.scoring = scoring_ff;
   assign status.hold    = hold_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         hit_ff            <= '0;
         short_ff          <= '0;
         pressing_ff       <= '0;
         press_start_ff[0] <= '0;
         press_start_ff[1] <= '0;
         scoring_ff        <= 1'b0;
         hold_ff           <= 1'b0;
         buzz_ff           <= 1'b0;
         lockout_start_ff  <= '0;
         hold_start_ff     <= '0;
         buzz_start_ff     <= '0;
      end else if (step) begin
         hit_ff            <= hit_in;
         short_ff          <= short_in;
         pressing_ff       <= pressing_in;
         press_start_ff[0] <= press_start_in[0];
         press_start_ff[1] <= press_start_in[1];
         scoring_ff        <= scoring_in;
         hold_ff           <= hold_in;
         buzz_ff           <= buzz_in;
         lockout_start_ff  <= lockout_start_in;
         hold_start_ff     <= hold_start_in;
         buzz_start_ff     <= buzz_start_in;
      end
   end

endmodule

`default_nettype wire

[design/fencing_hit_detector_unit.sv]
// ----------------------------------------------------------------------------
// Fencing hit detector unit
// Scores foil, epee and sabre contacts from one ADC sample set per item.
//
// Input channel req_*: six line samples and a microsecond timestamp per item.
// Result channel rsp_*: hit flags, new-hit codes, shorts, strip ground,
// buzzer level and bout phase after that item, one result per item.
// Configuration port csr_*: weapon mode, buzzer hold and light hold; a write
// of the weapon mode clears the bout state.
// Path: an item is accepted into the input register, and its result is then
// written to the result register when that register is free or being taken.
// Throughput: one item per cycle while rsp_stall is low; the bout state
// update for one item is combinational between input and result registers.
// Reset: bout state clears, mode returns to epee, hold times to defaults.
// Stall: a stalled result holds in the result register while one more item
// waits in the input register; req_stall rises only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fencing_hit_detector_unit_defines.svh"

module fencing_hit_detector_unit #(
   parameter int SAMPLE_BITS = 10,
   parameter int TIME_BITS   = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [SAMPLE_BITS-1:0]              req_weapon_a,
   input  wire logic [SAMPLE_BITS-1:0]              req_weapon_b,
   input  wire logic [SAMPLE_BITS-1:0]              req_lame_a,
   input  wire logic [SAMPLE_BITS-1:0]              req_lame_b,
   input  wire logic [SAMPLE_BITS-1:0]              req_ground_a,
   input  wire logic [SAMPLE_BITS-1:0]              req_ground_b,
   input  wire logic [TIME_BITS-1:0]                req_time_us,

   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_on_target_a,
   output      logic                                rsp_off_target_a,
   output      logic                                rsp_on_target_b,
   output      logic                                rsp_off_target_b,
   output      logic                                rsp_short_fault_a,
   output      logic                                rsp_short_fault_b,
   output      logic                                rsp_strip_ground_a,
   output      logic                                rsp_strip_ground_b,
   output      logic                                rsp_buzzer_on,
   output      logic [1:0]                          rsp_phase,
   output      logic [1:0]                          rsp_new_hit_a,
   output      logic [1:0]                          rsp_new_hit_b,

   input  wire logic                                csr_write_en,
   input  wire logic [fhd_pkg::CsrIndexBits-1:0]    csr_index,
   input  wire logic [fhd_pkg::CsrDataBits-1:0]     csr_wdata
);
   import fhd_pkg::*;

   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_weapon_a_ff, s1_weapon_b_ff;
   logic [SAMPLE_BITS-1:0] s1_lame_a_ff, s1_lame_b_ff;
   logic [SAMPLE_BITS-1:0] s1_ground_a_ff, s1_ground_b_ff;
   logic [TIME_BITS-1:0]   s1_time_ff;
   logic                   rsp_valid_ff;
   result_type             rsp_ff;
   result_type             core_result;
   core_status_type        core_status;
   weapon_mode_type        mode_ff;
   logic [HoldBits-1:0]    buzzer_hold_ff, light_hold_ff;
   line_class_type         class_a, class_b;
   logic                   advance, req_take, clear_state;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign clear_state = csr_write_en && (csr_index == CSR_WEAPON_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_EPEE;
         buzzer_hold_ff <= BUZZER_HOLD_RESET;
         light_hold_ff  <= LIGHT_HOLD_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WEAPON_MODE: mode_ff        <= weapon_mode_type'(csr_wdata[1:0]);
            CSR_BUZZER_HOLD: buzzer_hold_ff <= csr_wdata[HoldBits-1:0];
            CSR_LIGHT_HOLD:  light_hold_ff  <= csr_wdata[HoldBits-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_weapon_a_ff <= req_weapon_a;
         s1_weapon_b_ff <= req_weapon_b;
         s1_lame_a_ff   <= req_lame_a;
         s1_lame_b_ff   <= req_lame_b;
         s1_ground_a_ff <= req_ground_a;
         s1_ground_b_ff <= req_ground_b;
         s1_time_ff     <= req_time_us;
      end
   end

   fhd_line_class #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_class_a (
      .own_weapon (s1_weapon_a_ff),
      .own_lame   (s1_lame_a_ff),
      .opp_lame   (s1_lame_b_ff),
      .own_ground (s1_ground_a_ff),
      .line_class (class_a)
   );

   fhd_line_class #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_class_b (
      .own_weapon (s1_weapon_b_ff),
      .own_lame   (s1_lame_b_ff),
      .opp_lame   (s1_lame_a_ff),
      .own_ground (s1_ground_b_ff),
      .line_class (class_b)
   );

   fhd_score_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear_state),
      .step        (advance),
      .mode        (mode_ff),
      .buzzer_hold (buzzer_hold_ff),
      .light_hold  (light_hold_ff),
      .now         (s1_time_ff),
      .class_a     (class_a),
      .class_b     (class_b),
      .result      (core_result),
      .status      (core_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_on_target_a    = rsp_ff.on_target_a;
   assign rsp_off_target_a   = rsp_ff.off_target_a;
   assign rsp_on_target_b    = rsp_ff.on_target_b;
   assign rsp_off_target_b   = rsp_ff.off_target_b;
   assign rsp_short_fault_a  = rsp_ff.short_fault_a;
   assign rsp_short_fault_b  = rsp_ff.short_fault_b;
   assign rsp_strip_ground_a = rsp_ff.strip_ground_a;
   assign rsp_strip_ground_b = rsp_ff.strip_ground_b;
   assign rsp_buzzer_on      = rsp_ff.buzzer_on;
   assign rsp_phase          = rsp_ff.phase;
   assign rsp_new_hit_a      = rsp_ff.new_hit_a;
   assign rsp_new_hit_b      = rsp_ff.new_hit_b;

   `FHD_ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff && rsp_stall, "input stalled while a stage was free")
   `FHD_ASSERT_IMPLY(a_buzzer_in_bout, clock, reset, rsp_valid && rsp_buzzer_on, rsp_phase != PHASE_IDLE, "buzzer on with bout idle")
   `FHD_ASSERT_IMPLY(a_hold_in_bout, clock, reset, core_status.hold, core_status.scoring, "light hold without scoring")
   `FHD_ASSERT_NEXT(a_mode_write_clears, clock, reset, clear_state, !core_status.scoring && !core_status.hold, "mode write left bout state")

endmodule

`default_nettype wire
